/* rtl/pbcb_pkg.sv */
// Shared types and constants for the packed bitmap clear blitter.
// No dependencies; imported by the controller and the top level.
`timescale 1ns / 1ps

package pbcb_pkg;

  localparam int unsigned IMAGE_WORDS_DEF      = 1024;
  localparam int unsigned DISPLAY_SIDE_DEF     = 128;
  localparam int unsigned WORDS_PER_COLUMN_DEF = 4;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ADDR_W   = 10;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned HEIGHT_W = 6;
  localparam int unsigned BIT_W    = 5;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 6'd32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_BLIT  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_WRITE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MOD_Q,
    ST_MOD_R,
    ST_BLIT
  } state_e;

  // Pull h bits of the stream out of two adjacent image words.
  function automatic logic [WORD_W-1:0] stream_bits(
    input logic [WORD_W-1:0] lo_word,
    input logic [WORD_W-1:0] hi_word,
    input logic [BIT_W-1:0]  shift,
    input logic [WORD_W-1:0] mask
  );
    logic [2*WORD_W-1:0] joined;
    joined = {hi_word, lo_word} >> shift;
    return joined[WORD_W-1:0] & mask;
  endfunction

endpackage

/* rtl/pbcb_ram.sv */
// Synchronous RAM, one write port and two registered read ports.
// Used for both the image store and the display store; no dependencies.
`timescale 1ns / 1ps

module pbcb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned Aw   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_a_i,
  input  logic [Aw-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* rtl/pbcb_ctrl.sv */
// Item sequencer: handshake, clearing pass, blit column pipeline with
// read-modify-write of the display store. Depends on pbcb_pkg.
`timescale 1ns / 1ps

module pbcb_ctrl #(
  parameter int unsigned IMAGE_WORDS      = pbcb_pkg::IMAGE_WORDS_DEF,
  parameter int unsigned DISPLAY_SIDE     = pbcb_pkg::DISPLAY_SIDE_DEF,
  parameter int unsigned WORDS_PER_COLUMN = pbcb_pkg::WORDS_PER_COLUMN_DEF,
  localparam int unsigned ImgAw  = $clog2(IMAGE_WORDS),
  localparam int unsigned DispAw = $clog2(DISPLAY_SIDE * WORDS_PER_COLUMN)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pbcb_pkg::FUNC_W-1:0]         func_i,
  input  logic [pbcb_pkg::ADDR_W-1:0]         addr_i,
  input  logic [pbcb_pkg::WORD_W-1:0]         word_data_i,
  input  logic [pbcb_pkg::POS_W-1:0]          pos_x_i,
  input  logic [pbcb_pkg::POS_W-1:0]          pos_y_i,
  input  logic [pbcb_pkg::POS_W-1:0]          img_width_i,
  input  logic [pbcb_pkg::HEIGHT_W-1:0]       img_height_i,
  input  logic [pbcb_pkg::ADDR_W-1:0]         start_word_i,
  input  logic [pbcb_pkg::BIT_W-1:0]          start_bit_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pbcb_pkg::WORD_W-1:0]         read_data_o,
  output logic                                clipped_o,
  output logic                                img_we_o,
  output logic [ImgAw-1:0]                    img_waddr_o,
  output logic [pbcb_pkg::WORD_W-1:0]         img_wdata_o,
  output logic [ImgAw-1:0]                    img_raddr_a_o,
  output logic [ImgAw-1:0]                    img_raddr_b_o,
  input  logic [pbcb_pkg::WORD_W-1:0]         img_rdata_a_i,
  input  logic [pbcb_pkg::WORD_W-1:0]         img_rdata_b_i,
  output logic                                disp_we_o,
  output logic [DispAw-1:0]                   disp_waddr_o,
  output logic [pbcb_pkg::WORD_W-1:0]         disp_wdata_o,
  output logic [DispAw-1:0]                   disp_raddr_a_o,
  output logic [DispAw-1:0]                   disp_raddr_b_o,
  input  logic [pbcb_pkg::WORD_W-1:0]         disp_rdata_a_i,
  input  logic [pbcb_pkg::WORD_W-1:0]         disp_rdata_b_i
);

  import pbcb_pkg::*;

  localparam int unsigned DispWords = DISPLAY_SIDE * WORDS_PER_COLUMN;
  localparam int unsigned IdxW      = $clog2(WORDS_PER_COLUMN * 256 + 8);
  // start_word mod IMAGE_WORDS by reciprocal; exact for all 10-bit inputs
  localparam int unsigned ModK      = ADDR_W + ImgAw;
  localparam int unsigned Recip     = ((2 ** ModK) + IMAGE_WORDS - 1) / IMAGE_WORDS;
  localparam int unsigned RecipW    = $clog2(Recip + 1);
  localparam int unsigned ProdW     = ADDR_W + RecipW;

  state_e state_q, state_d;

  // control
  logic                out_valid_q, out_valid_d;
  logic                p2_vld_q, p2_vld_d;
  logic                wr1_pend_q, wr1_pend_d;
  logic                clip_q, clip_d;
  logic [DispAw-1:0]   clr_cnt_q;

  // payload
  logic [WORD_W-1:0]   read_data_q;
  logic                clipped_q;
  logic [POS_W-1:0]    width_q, col_q, x_q;
  logic [HEIGHT_W-1:0] h_q;
  logic [WORD_W-1:0]   mask_q;
  logic [2:0]          doff_q;
  logic [BIT_W-1:0]    dbit_q;
  logic                straddle_q;
  logic [ADDR_W-1:0]   sw_q, q_q;
  logic [ImgAw-1:0]    wi_q;
  logic [BIT_W-1:0]    bi_q;
  logic [BIT_W-1:0]    s2_bi_q;
  logic [DispAw-1:0]   s2_addr0_q, s2_addr1_q;
  logic                s2_ok0_q, s2_ok1_q;
  logic [DispAw-1:0]   wr1_addr_q;
  logic [WORD_W-1:0]   wr1_data_q;
  logic                fwd0_q, fwd1_q;
  logic [WORD_W-1:0]   fwd_data_q;

  logic                accept, issue, blit_done;
  func_e               func;
  logic                disp_addr_ok, img_addr_ok;
  logic [HEIGHT_W-1:0] h_sat;
  logic [POS_W-1:0]    top;
  logic [HEIGHT_W-1:0] room;
  logic [WORD_W-1:0]   mask_new;
  logic [ImgAw-1:0]    wi_nx;
  logic [IdxW-1:0]     didx, didx1;
  logic                ok0, ok1;
  logic [HEIGHT_W-1:0] bsum;
  logic [WORD_W-1:0]   rd0, rd1, pix, new0, new1;
  logic [2*WORD_W-1:0] clr_bits;
  logic [ProdW-1:0]    prod;
  logic [ADDR_W-1:0]   rem;

  assign func         = func_e'(func_i);
  assign in_ready_o   = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept       = in_valid_i && in_ready_o;
  assign disp_addr_ok = 32'(addr_i) < DispWords;
  assign img_addr_ok  = 32'(addr_i) < IMAGE_WORDS;

  // blit geometry, latched at accept
  assign h_sat    = (img_height_i > HEIGHT_MAX) ? HEIGHT_MAX : img_height_i;
  assign top      = POS_W'(DISPLAY_SIDE) - pos_y_i - POS_W'(h_sat) + 8'd1;
  assign room     = HEIGHT_MAX - HEIGHT_W'(top[BIT_W-1:0]);
  assign mask_new = h_sat[BIT_W] ? '1 : ((32'd1 << h_sat[BIT_W-1:0]) - 32'd1);

  // column address generation
  assign wi_nx = (wi_q == ImgAw'(IMAGE_WORDS - 1)) ? '0 : wi_q + 1'b1;
  assign didx  = IdxW'(WORDS_PER_COLUMN * x_q) + IdxW'(doff_q);
  assign didx1 = didx + 1'b1;
  assign ok0   = didx < IdxW'(DispWords);
  assign ok1   = didx1 < IdxW'(DispWords);
  assign bsum  = HEIGHT_W'(bi_q) + h_q;

  // second stage: read data arrives, modify
  assign rd0      = fwd0_q ? fwd_data_q : disp_rdata_a_i;
  assign rd1      = fwd1_q ? fwd_data_q : disp_rdata_b_i;
  assign pix      = stream_bits(img_rdata_a_i, img_rdata_b_i, s2_bi_q, mask_q);
  assign clr_bits = {32'd0, pix} << dbit_q;
  assign new0     = rd0 & ~clr_bits[WORD_W-1:0];
  assign new1     = rd1 & ~clr_bits[2*WORD_W-1:WORD_W];

  assign prod = ProdW'(sw_q) * ProdW'(Recip);
  assign rem  = sw_q - ADDR_W'(q_q * IMAGE_WORDS);

  // one column per cycle, but when the columns straddle a display word and need a
  // second write, a column issues only while the second stage is empty
  assign issue     = (state_q == ST_BLIT) && (col_q != width_q) &&
                     !(p2_vld_q && straddle_q);
  assign blit_done = (state_q == ST_BLIT) && (col_q == width_q) &&
                     !p2_vld_q && !wr1_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    img_we_o       = 1'b0;
    img_waddr_o    = ImgAw'(addr_i);
    img_wdata_o    = word_data_i;
    img_raddr_a_o  = wi_q;
    img_raddr_b_o  = wi_nx;
    disp_we_o      = 1'b0;
    disp_waddr_o   = DispAw'(addr_i);
    disp_wdata_o   = word_data_i;
    disp_raddr_a_o = didx[DispAw-1:0];
    disp_raddr_b_o = didx1[DispAw-1:0];
    out_valid_d    = out_valid_q && !out_ready_i;
    p2_vld_d       = issue;
    wr1_pend_d     = 1'b0;
    clip_d         = clip_q;

    unique case (state_q)
      ST_CLEAR: begin
        disp_we_o    = 1'b1;
        disp_waddr_o = clr_cnt_q;
        disp_wdata_o = '1;
        if (clr_cnt_q == DispAw'(DispWords - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        disp_raddr_a_o = DispAw'(addr_i);
        if (accept) begin
          clip_d = 1'b0;
          unique case (func)
            FUNC_LOAD: begin
              img_we_o    = img_addr_ok;
              out_valid_d = 1'b1;
            end
            FUNC_WRITE: begin
              disp_we_o   = disp_addr_ok;
              out_valid_d = 1'b1;
            end
            FUNC_READ: begin
              if (disp_addr_ok) begin
                state_d = ST_READ;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            FUNC_BLIT: begin
              state_d = ST_MOD_Q;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_MOD_Q: begin
        state_d = ST_MOD_R;
      end
      ST_MOD_R: begin
        state_d = ST_BLIT;
      end
      ST_BLIT: begin
        priority if (wr1_pend_q) begin
          disp_we_o    = 1'b1;
          disp_waddr_o = wr1_addr_q;
          disp_wdata_o = wr1_data_q;
        end else if (p2_vld_q) begin
          disp_we_o    = s2_ok0_q;
          disp_waddr_o = s2_addr0_q;
          disp_wdata_o = new0;
          wr1_pend_d   = straddle_q && s2_ok1_q;
          clip_d       = clip_q || !s2_ok0_q || (straddle_q && !s2_ok1_q);
        end
        if (blit_done) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      p2_vld_q    <= 1'b0;
      wr1_pend_q  <= 1'b0;
      clip_q      <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      p2_vld_q    <= p2_vld_d;
      wr1_pend_q  <= wr1_pend_d;
      clip_q      <= clip_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // catch a write that lands on an address being read this cycle
    fwd0_q     <= disp_we_o && (disp_waddr_o == disp_raddr_a_o);
    fwd1_q     <= disp_we_o && (disp_waddr_o == disp_raddr_b_o);
    fwd_data_q <= disp_wdata_o;

    if (accept) begin
      read_data_q <= '0;
      clipped_q   <= (func == FUNC_READ || func == FUNC_WRITE) && !disp_addr_ok;
      width_q     <= img_width_i;
      col_q       <= '0;
      x_q         <= pos_x_i;
      h_q         <= h_sat;
      mask_q      <= mask_new;
      doff_q      <= top[POS_W-1:BIT_W];
      dbit_q      <= top[BIT_W-1:0];
      straddle_q  <= room < h_sat;
      sw_q        <= start_word_i;
      bi_q        <= start_bit_i;
    end
    if (state_q == ST_READ) begin
      read_data_q <= rd0;
      clipped_q   <= 1'b0;
    end
    if (blit_done) begin
      read_data_q <= '0;
      clipped_q   <= clip_q;
    end
    if (state_q == ST_MOD_Q) begin
      q_q <= ADDR_W'(prod >> ModK);
    end
    if (state_q == ST_MOD_R) begin
      wi_q <= ImgAw'(rem);
    end
    if (issue) begin
      col_q      <= col_q + 1'b1;
      x_q        <= x_q + 1'b1;
      bi_q       <= bsum[BIT_W-1:0];
      if (bsum[BIT_W]) begin
        wi_q <= wi_nx;
      end
      s2_bi_q    <= bi_q;
      s2_addr0_q <= didx[DispAw-1:0];
      s2_addr1_q <= didx1[DispAw-1:0];
      s2_ok0_q   <= ok0;
      s2_ok1_q   <= ok1;
    end
    if (state_q == ST_BLIT && !wr1_pend_q && p2_vld_q) begin
      wr1_addr_q <= s2_addr1_q;
      wr1_data_q <= new1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign clipped_o   = clipped_q;

endmodule

/* rtl/packed_bitmap_clear_blitter_top.sv */
// Top level of the packed bitmap clear blitter: image RAM, display RAM
// and the item sequencer. Depends on pbcb_pkg, pbcb_ram and pbcb_ctrl.
//
//   channel  handshake                  payload
//   in       in_valid_i / in_ready_o    func_i addr_i word_data_i pos_x_i pos_y_i
//                                       img_width_i img_height_i start_word_i
//                                       start_bit_i
//   out      out_valid_o / out_ready_i  read_data_o clipped_o
//
// Load and write items answer from idle; an in-range display read passes through a
// read state first. A blit issues its columns, and a column straddling two display
// words needs a second write: the single display write port sets the column rate.
// After reset the display RAM is swept to all ones, one word a cycle, over all
// DISPLAY_SIDE * WORDS_PER_COLUMN words (512 by default) before in_ready_o rises.
// A new item is taken while a result waits only if it is drained.
`timescale 1ns / 1ps

module packed_bitmap_clear_blitter_top #(
  parameter int unsigned IMAGE_WORDS      = pbcb_pkg::IMAGE_WORDS_DEF,
  parameter int unsigned DISPLAY_SIDE     = pbcb_pkg::DISPLAY_SIDE_DEF,
  parameter int unsigned WORDS_PER_COLUMN = pbcb_pkg::WORDS_PER_COLUMN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pbcb_pkg::FUNC_W-1:0]   func_i,
  input  logic [pbcb_pkg::ADDR_W-1:0]   addr_i,
  input  logic [pbcb_pkg::WORD_W-1:0]   word_data_i,
  input  logic [pbcb_pkg::POS_W-1:0]    pos_x_i,
  input  logic [pbcb_pkg::POS_W-1:0]    pos_y_i,
  input  logic [pbcb_pkg::POS_W-1:0]    img_width_i,
  input  logic [pbcb_pkg::HEIGHT_W-1:0] img_height_i,
  input  logic [pbcb_pkg::ADDR_W-1:0]   start_word_i,
  input  logic [pbcb_pkg::BIT_W-1:0]    start_bit_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pbcb_pkg::WORD_W-1:0]   read_data_o,
  output logic                          clipped_o
);

  import pbcb_pkg::*;

  localparam int unsigned DispWords = DISPLAY_SIDE * WORDS_PER_COLUMN;
  localparam int unsigned ImgAw     = $clog2(IMAGE_WORDS);
  localparam int unsigned DispAw    = $clog2(DispWords);

  logic              img_we, disp_we;
  logic [ImgAw-1:0]  img_waddr, img_raddr_a, img_raddr_b;
  logic [DispAw-1:0] disp_waddr, disp_raddr_a, disp_raddr_b;
  logic [WORD_W-1:0] img_wdata, img_rdata_a, img_rdata_b;
  logic [WORD_W-1:0] disp_wdata, disp_rdata_a, disp_rdata_b;

  pbcb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (IMAGE_WORDS)
  ) u_img_ram (
    .clk_i     (clk_i),
    .we_i      (img_we),
    .waddr_i   (img_waddr),
    .wdata_i   (img_wdata),
    .raddr_a_i (img_raddr_a),
    .raddr_b_i (img_raddr_b),
    .rdata_a_o (img_rdata_a),
    .rdata_b_o (img_rdata_b)
  );

  pbcb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DispWords)
  ) u_disp_ram (
    .clk_i     (clk_i),
    .we_i      (disp_we),
    .waddr_i   (disp_waddr),
    .wdata_i   (disp_wdata),
    .raddr_a_i (disp_raddr_a),
    .raddr_b_i (disp_raddr_b),
    .rdata_a_o (disp_rdata_a),
    .rdata_b_o (disp_rdata_b)
  );

  pbcb_ctrl #(
    .IMAGE_WORDS      (IMAGE_WORDS),
    .DISPLAY_SIDE     (DISPLAY_SIDE),
    .WORDS_PER_COLUMN (WORDS_PER_COLUMN)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .addr_i         (addr_i),
    .word_data_i    (word_data_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .img_width_i    (img_width_i),
    .img_height_i   (img_height_i),
    .start_word_i   (start_word_i),
    .start_bit_i    (start_bit_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .clipped_o      (clipped_o),
    .img_we_o       (img_we),
    .img_waddr_o    (img_waddr),
    .img_wdata_o    (img_wdata),
    .img_raddr_a_o  (img_raddr_a),
    .img_raddr_b_o  (img_raddr_b),
    .img_rdata_a_i  (img_rdata_a),
    .img_rdata_b_i  (img_rdata_b),
    .disp_we_o      (disp_we),
    .disp_waddr_o   (disp_waddr),
    .disp_wdata_o   (disp_wdata),
    .disp_raddr_a_o (disp_raddr_a),
    .disp_raddr_b_o (disp_raddr_b),
    .disp_rdata_a_i (disp_rdata_a),
    .disp_rdata_b_i (disp_rdata_b)
  );

endmodule

/* tb/sv/packed_bitmap_clear_blitter_top_test.sv */
// Self-checking testbench for packed_bitmap_clear_blitter_top: mirrors the image and display
// stores, predicts every result and compares it against the block's output channel.
// Depends on pbcb_pkg and the blitter RTL only.
`timescale 1ns / 1ps

module packed_bitmap_clear_blitter_top_test;
  import pbcb_pkg::*;

  localparam int unsigned IMG_WORDS  = IMAGE_WORDS_DEF;
  localparam int unsigned DISP_SIDE  = DISPLAY_SIDE_DEF;
  localparam int unsigned COL_WORDS  = WORDS_PER_COLUMN_DEF;
  localparam int unsigned DISP_WORDS = DISP_SIDE * COL_WORDS;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    func_e               func;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   word_data;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [POS_W-1:0]    img_width;
    logic [HEIGHT_W-1:0] img_height;
    logic [ADDR_W-1:0]   start_word;
    logic [BIT_W-1:0]    start_bit;
  } blit_item_t;

  typedef struct {
    logic [WORD_W-1:0] read_data;
    logic              clipped;
  } blit_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, clipped_o;
  logic [WORD_W-1:0] read_data_o;

  blit_item_t drv_item = '{func: FUNC_LOAD, default: '0};

  packed_bitmap_clear_blitter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (drv_item.func),
    .addr_i       (drv_item.addr),
    .word_data_i  (drv_item.word_data),
    .pos_x_i      (drv_item.pos_x),
    .pos_y_i      (drv_item.pos_y),
    .img_width_i  (drv_item.img_width),
    .img_height_i (drv_item.img_height),
    .start_word_i (drv_item.start_word),
    .start_bit_i  (drv_item.start_bit),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .clipped_o    (clipped_o)
  );

  always #5 clk_i = ~clk_i;

  // Mirrors of the two stores, updated as items are accepted.
  logic [WORD_W-1:0] image_mirror   [IMG_WORDS];
  logic [WORD_W-1:0] display_mirror [DISP_WORDS];
  // Which image words the stimulus has loaded so far.
  bit                img_loaded     [IMG_WORDS];

  blit_item_t   queued_items [$];
  blit_result_t due_results  [$];

  int unsigned phase = 0;
  int unsigned sender_idle_pct [3] = '{31, 71, 0};
  int unsigned recv_idle_pct   [3] = '{71, 31, 0};
  int unsigned gen_cnt = 0;
  int unsigned func_tally [4] = '{0, 0, 0, 0};
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned clip_cnt     = 0;
  int unsigned fail_cnt     = 0;
  int unsigned hold_at      = 32'hFFFF_FFFF;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  function automatic logic clear_display_bits(input int unsigned idx,
                                              input logic [WORD_W-1:0] bits);
    if (idx >= DISP_WORDS) return 1'b1;
    display_mirror[idx] &= ~bits;
    return 1'b0;
  endfunction

  function automatic blit_result_t apply_item(input blit_item_t it);
    blit_result_t res;
    int unsigned h, top, wi, bi, col, x, didx, dbit, got, room;
    logic [WORD_W-1:0] mask, pix;
    res.read_data = '0;
    res.clipped   = 1'b0;
    case (it.func)
      FUNC_LOAD: begin
        image_mirror[it.addr] = it.word_data;
      end
      FUNC_READ: begin
        if (it.addr < DISP_WORDS) res.read_data = display_mirror[it.addr];
        else res.clipped = 1'b1;
      end
      FUNC_WRITE: begin
        if (it.addr < DISP_WORDS) display_mirror[it.addr] = it.word_data;
        else res.clipped = 1'b1;
      end
      default: begin
        h    = (it.img_height > 32) ? 32 : it.img_height;
        mask = (h >= 32) ? 32'hFFFF_FFFF : (32'd1 << h) - 32'd1;
        top  = (DISP_SIDE - it.pos_y - h + 1) & 32'hFF;
        wi   = it.start_word % IMG_WORDS;
        bi   = it.start_bit;
        for (col = 0; col < it.img_width; col++) begin
          x    = (it.pos_x + col) & 32'hFF;
          didx = COL_WORDS * x + top / 32;
          dbit = top % 32;
          pix  = (image_mirror[wi] & (mask << bi)) >> bi;
          // Column runs past the end of this image word: take the rest from the next.
          if (bi + h > 32) begin
            got = 32 - bi;
            wi  = (wi + 1) % IMG_WORDS;
            pix |= (image_mirror[wi] & (mask >> got)) << got;
            bi  = h - got;
          end else begin
            bi += h;
            wi  = (wi + bi / 32) % IMG_WORDS;
            bi  = bi % 32;
          end
          res.clipped |= clear_display_bits(didx, pix << dbit);
          room = 32 - dbit;
          if (room < h) res.clipped |= clear_display_bits(didx + 1, pix >> room);
        end
      end
    endcase
    return res;
  endfunction

  // Driver: offer queued items, predict each one as it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        due_results.push_back(apply_item(drv_item));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (queued_items.size() != 0 && $urandom_range(99) >= sender_idle_pct[phase]) begin
          drv_item   <= queued_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, early in the last phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && phase == 2 && accepted_cnt >= hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    blit_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          $error("result with no item outstanding: read_data %h clipped %b",
                 read_data_o, clipped_o);
          fail_cnt++;
        end else begin
          want = due_results.pop_front();
          checked_cnt++;
          if (clipped_o === 1'b1) clip_cnt++;
          if (read_data_o !== want.read_data) begin
            $error("read_data: expected %h, actual %h", want.read_data, read_data_o);
            fail_cnt++;
          end
          if (clipped_o !== want.clipped) begin
            $error("clipped: expected %b, actual %b", want.clipped, clipped_o);
            fail_cnt++;
          end
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct[phase]);
    end
  end

  task automatic push_item(input func_e f, input int unsigned a, input logic [WORD_W-1:0] d);
    blit_item_t it;
    it.func       = f;
    it.addr       = ADDR_W'(a);
    it.word_data  = d;
    it.pos_x      = POS_W'($urandom());
    it.pos_y      = POS_W'($urandom());
    it.img_width  = POS_W'($urandom());
    it.img_height = HEIGHT_W'($urandom());
    it.start_word = ADDR_W'($urandom());
    it.start_bit  = BIT_W'($urandom());
    if (f == FUNC_LOAD) img_loaded[it.addr] = 1'b1;
    queued_items.push_back(it);
    func_tally[f]++;
    gen_cnt++;
  endtask

  // Queue a blit, first loading every image word its stream walk may touch.
  task automatic push_blit(input int unsigned px, input int unsigned py, input int unsigned w,
                           input int unsigned h, input int unsigned sw, input int unsigned sb);
    blit_item_t it;
    int unsigned hs, wi, bi, col, k, idx;
    it.func       = FUNC_BLIT;
    it.addr       = ADDR_W'($urandom());
    it.word_data  = $urandom();
    it.pos_x      = POS_W'(px);
    it.pos_y      = POS_W'(py);
    it.img_width  = POS_W'(w);
    it.img_height = HEIGHT_W'(h);
    it.start_word = ADDR_W'(sw);
    it.start_bit  = BIT_W'(sb);
    hs = (h > 32) ? 32 : h;
    wi = sw % IMG_WORDS;
    bi = sb;
    for (col = 0; col < w; col++) begin
      for (k = 0; k < 2; k++) begin
        idx = (wi + k) % IMG_WORDS;
        if (!img_loaded[idx]) push_item(FUNC_LOAD, idx, $urandom());
      end
      if (bi + hs > 32) begin
        bi = hs - (32 - bi);
        wi = (wi + 1) % IMG_WORDS;
      end else begin
        bi += hs;
        wi  = (wi + bi / 32) % IMG_WORDS;
        bi  = bi % 32;
      end
    end
    queued_items.push_back(it);
    func_tally[FUNC_BLIT]++;
    gen_cnt++;
  endtask

  task automatic gen_random(input int unsigned count);
    int unsigned stop_at, pick, k, w, h, hs, px, py, top, da, n;
    stop_at = gen_cnt + count;
    while (gen_cnt < stop_at) begin
      pick = $urandom_range(99);
      da   = ($urandom_range(99) < 80) ? $urandom_range(DISP_WORDS - 1) : $urandom_range(1023);
      if (pick < 50) begin
        k = $urandom_range(99);
        w = (k < 70) ? $urandom_range(8) : (k < 90) ? $urandom_range(40, 9) :
            (k < 97) ? $urandom_range(128, 41) : $urandom_range(255, 129);
        k = $urandom_range(99);
        h = (k < 6) ? 0 : (k < 14) ? $urandom_range(63, 33) : $urandom_range(32, 1);
        hs = (h > 32) ? 32 : h;
        px = ($urandom_range(99) < 75) ? $urandom_range(DISP_SIDE - 1) : $urandom_range(255);
        if ($urandom_range(99) < 70) begin
          top = $urandom_range(DISP_SIDE - 1);
          py  = (DISP_SIDE + 1 - hs - top) & 32'hFF;
        end else begin
          py  = $urandom_range(255);
          top = (DISP_SIDE + 1 - py - hs) & 32'hFF;
        end
        push_blit(px, py, w, h, $urandom_range(IMG_WORDS - 1), $urandom_range(31));
        // Read back words around the first column so the clears are visible.
        if ($urandom_range(99) < 70) begin
          n = $urandom_range(3, 1);
          for (k = 0; k < n; k++)
            push_item(FUNC_READ, (COL_WORDS * px + top / 32 + $urandom_range(4)) % 1024,
                      $urandom());
        end
      end else if (pick < 62) begin
        push_item(FUNC_LOAD, $urandom_range(IMG_WORDS - 1), $urandom());
      end else if (pick < 80) begin
        push_item(FUNC_WRITE, da, $urandom_range(1) ? 32'hFFFF_FFFF : $urandom());
      end else begin
        push_item(FUNC_READ, da, $urandom());
      end
    end
  endtask

  task automatic wait_drained();
    while (queued_items.size() != 0 || in_valid_i || due_results.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < DISP_WORDS; i++) display_mirror[i] = 32'hFFFF_FFFF;
    for (int i = 0; i < IMG_WORDS; i++) image_mirror[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: store edges, clipping, stream and display straddles, height extremes.
    push_item(FUNC_READ, 0, '0);
    push_item(FUNC_READ, DISP_WORDS, '0);
    push_item(FUNC_WRITE, 1023, '0);
    push_item(FUNC_WRITE, DISP_WORDS - 1, 32'h0);
    push_item(FUNC_READ, DISP_WORDS - 1, '0);
    push_item(FUNC_WRITE, DISP_WORDS - 1, 32'hFFFF_FFFF);
    push_item(FUNC_LOAD, 0, 32'hFFFF_FFFF);
    push_item(FUNC_LOAD, IMG_WORDS - 1, 32'h8000_0001);
    push_blit(0, 97, 1, 32, 0, 0);
    push_item(FUNC_READ, 0, '0);
    push_blit(1, 89, 2, 20, IMG_WORDS - 1, 20);
    push_item(FUNC_READ, 4, '0);
    push_item(FUNC_READ, 5, '0);
    push_blit(DISP_SIDE - 1, 226, 1, 32, 5, 31);
    push_item(FUNC_READ, DISP_WORDS - 1, '0);
    push_blit(200, 0, 3, 0, 2, 0);
    push_blit(10, 97, 1, 40, 0, 7);
    push_item(FUNC_READ, 40, '0);
    push_blit(0, 0, 0, 5, 0, 0);
    push_blit(0, 128, 255, 1, 0, 31);
    push_item(FUNC_READ, 8, '0);

    gen_random(600);
    wait_drained();
    phase = 1;
    gen_random(600);
    wait_drained();
    hold_at = accepted_cnt + 100;
    phase = 2;
    gen_random(550);
    wait_drained();
    repeat (50) @(posedge clk_i);

    $display("summary: %0d items accepted (%0d loads, %0d blits, %0d reads, %0d writes)",
             accepted_cnt, func_tally[FUNC_LOAD], func_tally[FUNC_BLIT],
             func_tally[FUNC_READ], func_tally[FUNC_WRITE]);
    $display("summary: %0d results checked, %0d flagged clipped, %0d mismatches",
             checked_cnt, clip_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #25ms;
    $display("tb: failure");
    $finish;
  end

endmodule
